@@ hw/rtl/cpv_pkg.sv @@
`default_nettype none

package cpv_pkg;

    // Input action codes.
    localparam logic [1:0] ACT_BYTE    = 2'd0;
    localparam logic [1:0] ACT_TICK    = 2'd1;
    localparam logic [1:0] ACT_SESSION = 2'd2;

    // Packet status codes.
    localparam logic [1:0] ST_NONE      = 2'd0;
    localparam logic [1:0] ST_ACCEPTED  = 2'd1;
    localparam logic [1:0] ST_MALFORMED = 2'd2;
    localparam logic [1:0] ST_STALE     = 2'd3;

    // Configuration register indexes.
    localparam logic CFG_SHORT_VERSION = 1'b0;
    localparam logic CFG_TIMEOUT       = 1'b1;

    localparam int unsigned ASM_BYTES = 14;

    localparam logic [7:0]  LONG_FORMAT    = 8'd2;
    localparam logic [4:0]  LONG_LAST_IDX  = 5'd13;
    localparam logic [4:0]  SHORT_LAST_IDX = 5'd7;
    localparam logic [4:0]  IDX_LIMIT      = 5'd31;
    localparam logic [16:0] AGE_LIMIT      = 17'h1FFFF;

    localparam logic signed [16:0] SPEED_LIM = 17'sd1500;
    localparam logic signed [16:0] JOINT_LIM = 17'sd1571;

    typedef logic [ASM_BYTES-1:0][7:0] t_asm;

    typedef struct packed {
        logic               ok;
        logic [15:0]        seq;
        logic signed [11:0] fwd;
        logic signed [11:0] lat;
        logic signed [11:0] ja;
        logic signed [11:0] jb;
        logic signed [11:0] jc;
        logic [4:0]         modef;
    } t_decode;

    function automatic logic in_range(input logic [15:0] w, input logic signed [16:0] lim);
        logic signed [16:0] v;
        v = signed'({w[15], w});
        return (v >= -lim) && (v <= lim);
    endfunction

    function automatic logic seq_newer(input logic [15:0] cand, input logic [15:0] prev);
        logic [15:0] d;
        d = cand - prev;
        return (d != 16'd0) && !d[15];
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/cpv_decode.sv @@
`default_nettype none

module cpv_decode (
    input  wire cpv_pkg::t_asm    i_bytes,
    input  wire logic             i_len_long,
    input  wire logic             i_len_short,
    input  wire logic [7:0]       i_version,
    output cpv_pkg::t_decode      o_dec
);

    logic [7:0]  first;
    logic [7:0]  fl;
    logic [15:0] w_fwd;
    logic [15:0] w_lat;
    logic [15:0] w_ja;
    logic [15:0] w_jb;
    logic [15:0] w_jc;
    logic [15:0] w_seq_long;
    logic [15:0] w_seq_short;
    logic        speeds_ok;
    logic        joints_ok;
    logic        is_long;

    assign first       = i_bytes[0];
    assign fl          = i_bytes[1];
    assign w_fwd       = {i_bytes[3], i_bytes[2]};
    assign w_lat       = {i_bytes[5], i_bytes[4]};
    assign w_ja        = {i_bytes[7], i_bytes[6]};
    assign w_jb        = {i_bytes[9], i_bytes[8]};
    assign w_jc        = {i_bytes[11], i_bytes[10]};
    assign w_seq_long  = {i_bytes[13], i_bytes[12]};
    assign w_seq_short = {i_bytes[7], i_bytes[6]};

    assign is_long   = (first == cpv_pkg::LONG_FORMAT);
    assign speeds_ok = cpv_pkg::in_range(w_fwd, cpv_pkg::SPEED_LIM)
                    && cpv_pkg::in_range(w_lat, cpv_pkg::SPEED_LIM);
    assign joints_ok = cpv_pkg::in_range(w_ja, cpv_pkg::JOINT_LIM)
                    && cpv_pkg::in_range(w_jb, cpv_pkg::JOINT_LIM)
                    && cpv_pkg::in_range(w_jc, cpv_pkg::JOINT_LIM);

    always_comb begin
        o_dec.fwd = $signed(w_fwd[11:0]);
        o_dec.lat = $signed(w_lat[11:0]);
        if (is_long) begin
            // Mode bits both set select a mode that does not exist.
            o_dec.ok    = i_len_long && (fl[7:5] == 3'd0) && (fl[4:3] != 2'b11)
                       && speeds_ok && joints_ok;
            o_dec.ja    = $signed(w_ja[11:0]);
            o_dec.jb    = $signed(w_jb[11:0]);
            o_dec.jc    = $signed(w_jc[11:0]);
            o_dec.modef = fl[4:0];
            o_dec.seq   = w_seq_long;
        end else begin
            o_dec.ok    = i_len_short && (first == i_version) && (fl[7:3] == 5'd0)
                       && speeds_ok;
            o_dec.ja    = '0;
            o_dec.jb    = '0;
            o_dec.jc    = '0;
            o_dec.modef = {2'b00, fl[2:0]};
            o_dec.seq   = w_seq_short;
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/command_packet_validator_core.sv @@
// An accepted transaction is held in the input registers, and its result in the output registers.
// Throughput: one input transaction per cycle while the input is not stalled; every input yields exactly one result.
// The input stage stalls only while a result is held back by the output stall.
// Reset (synchronous, active low) clears the held command, its age and any partial
// packet, and restores short_format_version to 1 and timeout_ms to 250.
`default_nettype none

module command_packet_validator_core (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,

    input  wire logic               i_cfg_we,
    input  wire logic               i_cfg_index,
    input  wire logic [15:0]        i_cfg_data,

    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire logic [1:0]         i_action,
    input  wire logic [7:0]         i_data_byte,
    input  wire logic               i_last_byte,

    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output logic [1:0]              o_packet_status,
    output logic                    o_command_fresh,
    output logic signed [11:0]      o_forward_mm_s,
    output logic signed [11:0]      o_lateral_mm_s,
    output logic [1:0]              o_control_mode,
    output logic signed [11:0]      o_joint_a_mrad,
    output logic signed [11:0]      o_joint_b_mrad,
    output logic signed [11:0]      o_joint_c_mrad,
    output logic                    o_enable_request,
    output logic                    o_emergency_stop,
    output logic                    o_clear_fault,
    output logic [15:0]             o_held_sequence
);

    logic               r_in_vld;
    logic [1:0]         r_in_action;
    logic [7:0]         r_in_byte;
    logic               r_in_last;

    logic [7:0]         r_version;
    logic [15:0]        r_timeout;

    cpv_pkg::t_asm      r_asm;
    cpv_pkg::t_asm      n_asm;
    logic [4:0]         r_idx;
    logic [4:0]         n_idx;

    logic signed [11:0] r_fwd, n_fwd;
    logic signed [11:0] r_lat, n_lat;
    logic signed [11:0] r_ja, n_ja;
    logic signed [11:0] r_jb, n_jb;
    logic signed [11:0] r_jc, n_jc;
    logic [4:0]         r_modef, n_modef;
    logic [15:0]        r_held_seq, n_held_seq;
    logic               r_has_held, n_has_held;
    logic [16:0]        r_age, n_age;

    logic               r_out_vld;
    logic [1:0]         r_status, n_status;
    logic               r_fresh, n_fresh;

    logic               advance;
    cpv_pkg::t_decode   dec;

    assign advance    = r_in_vld && (!r_out_vld || !i_out_stall);
    assign o_in_stall = r_in_vld && r_out_vld && i_out_stall;

    // The byte of the current transaction is merged in before the packet is checked.
    always_comb begin
        n_asm = r_asm;
        if (r_in_action == cpv_pkg::ACT_BYTE && r_idx < 5'(cpv_pkg::ASM_BYTES)) begin
            n_asm[r_idx[3:0]] = r_in_byte;
        end
    end

    cpv_decode u_decode (
        .i_bytes     (n_asm),
        .i_len_long  (r_idx == cpv_pkg::LONG_LAST_IDX),
        .i_len_short (r_idx == cpv_pkg::SHORT_LAST_IDX),
        .i_version   (r_version),
        .o_dec       (dec)
    );

    always_comb begin
        n_idx      = r_idx;
        n_fwd      = r_fwd;
        n_lat      = r_lat;
        n_ja       = r_ja;
        n_jb       = r_jb;
        n_jc       = r_jc;
        n_modef    = r_modef;
        n_held_seq = r_held_seq;
        n_has_held = r_has_held;
        n_age      = r_age;
        n_status   = cpv_pkg::ST_NONE;
        case (r_in_action)
            cpv_pkg::ACT_BYTE: begin
                if (r_in_last) begin
                    n_idx = '0;
                    if (!dec.ok) begin
                        n_status = cpv_pkg::ST_MALFORMED;
                    end else if (r_has_held && !cpv_pkg::seq_newer(dec.seq, r_held_seq)) begin
                        n_status = cpv_pkg::ST_STALE;
                    end else begin
                        n_status   = cpv_pkg::ST_ACCEPTED;
                        n_fwd      = dec.fwd;
                        n_lat      = dec.lat;
                        n_ja       = dec.ja;
                        n_jb       = dec.jb;
                        n_jc       = dec.jc;
                        n_modef    = dec.modef;
                        n_held_seq = dec.seq;
                        n_has_held = 1'b1;
                        n_age      = '0;
                    end
                end else if (r_idx != cpv_pkg::IDX_LIMIT) begin
                    n_idx = r_idx + 5'd1;
                end
            end
            cpv_pkg::ACT_TICK: begin
                if (r_age != cpv_pkg::AGE_LIMIT) begin
                    n_age = r_age + 17'd1;
                end
            end
            cpv_pkg::ACT_SESSION: begin
                n_idx      = '0;
                n_fwd      = '0;
                n_lat      = '0;
                n_ja       = '0;
                n_jb       = '0;
                n_jc       = '0;
                n_modef    = '0;
                n_held_seq = '0;
                n_has_held = 1'b0;
                n_age      = '0;
            end
            default: begin
            end
        endcase
        n_fresh = n_has_held && (n_age <= {1'b0, r_timeout});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld   <= 1'b0;
            r_version  <= 8'd1;
            r_timeout  <= 16'd250;
            r_idx      <= '0;
            r_fwd      <= '0;
            r_lat      <= '0;
            r_ja       <= '0;
            r_jb       <= '0;
            r_jc       <= '0;
            r_modef    <= '0;
            r_held_seq <= '0;
            r_has_held <= 1'b0;
            r_age      <= '0;
            r_out_vld  <= 1'b0;
            r_status   <= cpv_pkg::ST_NONE;
            r_fresh    <= 1'b0;
        end else begin
            if (!o_in_stall) begin
                r_in_vld <= i_in_valid;
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    cpv_pkg::CFG_SHORT_VERSION: r_version <= i_cfg_data[7:0];
                    cpv_pkg::CFG_TIMEOUT:       r_timeout <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
            if (advance) begin
                r_idx      <= n_idx;
                r_fwd      <= n_fwd;
                r_lat      <= n_lat;
                r_ja       <= n_ja;
                r_jb       <= n_jb;
                r_jc       <= n_jc;
                r_modef    <= n_modef;
                r_held_seq <= n_held_seq;
                r_has_held <= n_has_held;
                r_age      <= n_age;
                r_status   <= n_status;
                r_fresh    <= n_fresh;
                r_out_vld  <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_vld  <= 1'b0;
            end
        end
    end

    // Payload registers: assembly bytes are written only as the transaction advances; the check uses the merged bytes.
    always_ff @(posedge i_clk) begin
        if (!o_in_stall) begin
            r_in_action <= i_action;
            r_in_byte   <= i_data_byte;
            r_in_last   <= i_last_byte;
        end
        if (advance) begin
            r_asm <= n_asm;
        end
    end

    assign o_out_valid      = r_out_vld;
    assign o_packet_status  = r_status;
    assign o_command_fresh  = r_fresh;
    assign o_forward_mm_s   = r_fwd;
    assign o_lateral_mm_s   = r_lat;
    assign o_control_mode   = r_modef[4:3];
    assign o_joint_a_mrad   = r_ja;
    assign o_joint_b_mrad   = r_jb;
    assign o_joint_c_mrad   = r_jc;
    assign o_enable_request = r_modef[0];
    assign o_emergency_stop = r_modef[1];
    assign o_clear_fault    = r_modef[2];
    assign o_held_sequence  = r_held_seq;

    a_accept_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_status == cpv_pkg::ST_ACCEPTED) |-> r_has_held)
        else $error("accepted transaction shown without a held command");

    a_accept_age: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_status == cpv_pkg::ST_ACCEPTED) |-> (r_age == 17'd0))
        else $error("accepted command does not start at age zero");

    a_empty_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_has_held |-> (r_held_seq == 16'd0 && !r_fresh && r_modef == 5'd0))
        else $error("held fields not cleared while no command is held");

endmodule

`default_nettype wire

@@ bench/testbench.sv @@
`timescale 1ns / 1ps

module testbench;

    localparam logic [1:0]  ACT_UNUSED   = 2'd3;
    localparam logic [4:0]  LONG_COUNT   = 5'd14;
    localparam logic [4:0]  SHORT_COUNT  = 5'd8;
    localparam logic [4:0]  COUNT_MAX    = 5'd31;
    localparam logic [16:0] AGE_MAX      = 17'h1FFFF;
    localparam int          SPEED_MAX    = 1500;
    localparam int          JOINT_MAX    = 1571;
    localparam int          AGE_RUN      = 60;
    localparam int          SETTLE_CYCLES = 6;
    localparam int unsigned CYCLE_LIMIT  = 2000000;

    typedef struct packed {
        logic [1:0] action;
        logic [7:0] data;
        logic       last;
    } t_cmd_input;

    typedef struct packed {
        logic [1:0]         status;
        logic               fresh;
        logic signed [11:0] fwd;
        logic signed [11:0] lat;
        logic [1:0]         mode;
        logic signed [11:0] ja;
        logic signed [11:0] jb;
        logic signed [11:0] jc;
        logic               enable;
        logic               estop;
        logic               clear;
        logic [15:0]        seq;
    } t_cmd_report;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic i_cfg_we;
    logic i_cfg_index;
    logic [15:0] i_cfg_data;
    logic i_in_valid;
    logic o_in_stall;
    logic [1:0] i_action;
    logic [7:0] i_data_byte;
    logic i_last_byte;
    logic o_out_valid;
    logic i_out_stall;
    logic [1:0] o_packet_status;
    logic o_command_fresh;
    logic signed [11:0] o_forward_mm_s;
    logic signed [11:0] o_lateral_mm_s;
    logic [1:0] o_control_mode;
    logic signed [11:0] o_joint_a_mrad;
    logic signed [11:0] o_joint_b_mrad;
    logic signed [11:0] o_joint_c_mrad;
    logic o_enable_request;
    logic o_emergency_stop;
    logic o_clear_fault;
    logic [15:0] o_held_sequence;

    command_packet_validator_core dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_action        (i_action),
        .i_data_byte     (i_data_byte),
        .i_last_byte     (i_last_byte),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_packet_status (o_packet_status),
        .o_command_fresh (o_command_fresh),
        .o_forward_mm_s  (o_forward_mm_s),
        .o_lateral_mm_s  (o_lateral_mm_s),
        .o_control_mode  (o_control_mode),
        .o_joint_a_mrad  (o_joint_a_mrad),
        .o_joint_b_mrad  (o_joint_b_mrad),
        .o_joint_c_mrad  (o_joint_c_mrad),
        .o_enable_request(o_enable_request),
        .o_emergency_stop(o_emergency_stop),
        .o_clear_fault   (o_clear_fault),
        .o_held_sequence (o_held_sequence)
    );

    always #5 i_clk = ~i_clk;

    // Shadow copy of the validator state.
    logic [7:0]  cfg_version;
    logic [15:0] cfg_timeout;
    logic [4:0]  asm_count;
    logic [7:0]  asm_bytes [0:13];
    logic [15:0] hold_cmd [0:4];
    logic [4:0]  hold_modef;
    logic [15:0] hold_seq;
    logic        has_cmd;
    logic [16:0] cmd_age;

    t_cmd_input  queued_events [$];
    t_cmd_report expected_reports [$];
    logic [7:0]  pkt [$];
    logic [15:0] gen_seq = 16'h0000;
    int          queued_items = 0;
    int          mismatches = 0;
    int unsigned cycle_count = 0;
    logic        hold_sender = 1'b1;
    int          send_idle_pct = 15;
    int          recv_idle_pct = 83;

    function automatic void clear_assembly();
        asm_count = '0;
        foreach (asm_bytes[i]) asm_bytes[i] = '0;
    endfunction

    function automatic void clear_held();
        foreach (hold_cmd[i]) hold_cmd[i] = '0;
        hold_modef = '0;
        hold_seq = '0;
        has_cmd = 1'b0;
        cmd_age = '0;
    endfunction

    function automatic logic fits_limit(logic [15:0] w, int lim);
        int v;
        v = int'($signed(w));
        return (v >= -lim) && (v <= lim);
    endfunction

    function automatic logic seq_is_newer(logic [15:0] cand, logic [15:0] prev);
        logic [15:0] d;
        d = cand - prev;
        return (d != 16'd0) && !d[15];
    endfunction

    // Decides the fate of the packet just framed and, if it is accepted, updates the held command.
    function automatic logic [1:0] close_packet();
        logic [15:0] w [0:4];
        logic [7:0]  fl;
        logic [4:0]  modef;
        logic [15:0] seq;
        fl = asm_bytes[1];
        for (int i = 0; i < 5; i++) w[i] = {asm_bytes[2*i+3], asm_bytes[2*i+2]};
        if (asm_bytes[0] == cpv_pkg::LONG_FORMAT) begin
            if (asm_count != LONG_COUNT || fl[7:5] != 3'b000 || fl[4:3] == 2'b11)
                return cpv_pkg::ST_MALFORMED;
            if (!fits_limit(w[0], SPEED_MAX) || !fits_limit(w[1], SPEED_MAX) ||
                !fits_limit(w[2], JOINT_MAX) || !fits_limit(w[3], JOINT_MAX) ||
                !fits_limit(w[4], JOINT_MAX))
                return cpv_pkg::ST_MALFORMED;
            modef = fl[4:0];
            seq = {asm_bytes[13], asm_bytes[12]};
        end else begin
            if (asm_count != SHORT_COUNT || asm_bytes[0] != cfg_version || fl[7:3] != 5'd0)
                return cpv_pkg::ST_MALFORMED;
            if (!fits_limit(w[0], SPEED_MAX) || !fits_limit(w[1], SPEED_MAX))
                return cpv_pkg::ST_MALFORMED;
            modef = {2'b00, fl[2:0]};
            seq = w[2];
            w[2] = '0;
            w[3] = '0;
            w[4] = '0;
        end
        if (has_cmd && !seq_is_newer(seq, hold_seq))
            return cpv_pkg::ST_STALE;
        hold_cmd = w;
        hold_modef = modef;
        hold_seq = seq;
        has_cmd = 1'b1;
        cmd_age = '0;
        return cpv_pkg::ST_ACCEPTED;
    endfunction

    function automatic t_cmd_report apply_event(t_cmd_input ev);
        t_cmd_report r;
        r.status = cpv_pkg::ST_NONE;
        case (ev.action)
            cpv_pkg::ACT_BYTE: begin
                if (asm_count < LONG_COUNT) asm_bytes[asm_count] = ev.data;
                if (asm_count < COUNT_MAX) asm_count = asm_count + 5'd1;
                if (ev.last) begin
                    r.status = close_packet();
                    clear_assembly();
                end
            end
            cpv_pkg::ACT_TICK: begin
                if (cmd_age != AGE_MAX) cmd_age = cmd_age + 17'd1;
            end
            cpv_pkg::ACT_SESSION: begin
                clear_held();
                clear_assembly();
            end
            default: ;
        endcase
        r.fresh  = has_cmd && (cmd_age <= {1'b0, cfg_timeout});
        r.fwd    = hold_cmd[0][11:0];
        r.lat    = hold_cmd[1][11:0];
        r.mode   = hold_modef[4:3];
        r.ja     = hold_cmd[2][11:0];
        r.jb     = hold_cmd[3][11:0];
        r.jc     = hold_cmd[4][11:0];
        r.enable = hold_modef[0];
        r.estop  = hold_modef[1];
        r.clear  = hold_modef[2];
        r.seq    = hold_seq;
        return r;
    endfunction

    task automatic check_field(string name, int want, int got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            mismatches++;
        end
    endtask

    task automatic check_report(t_cmd_report want);
        check_field("packet_status", want.status, o_packet_status);
        check_field("command_fresh", want.fresh, o_command_fresh);
        check_field("forward_mm_s", want.fwd, o_forward_mm_s);
        check_field("lateral_mm_s", want.lat, o_lateral_mm_s);
        check_field("control_mode", want.mode, o_control_mode);
        check_field("joint_a_mrad", want.ja, o_joint_a_mrad);
        check_field("joint_b_mrad", want.jb, o_joint_b_mrad);
        check_field("joint_c_mrad", want.jc, o_joint_c_mrad);
        check_field("enable_request", want.enable, o_enable_request);
        check_field("emergency_stop", want.estop, o_emergency_stop);
        check_field("clear_fault", want.clear, o_clear_fault);
        check_field("held_sequence", want.seq, o_held_sequence);
    endtask

    // Driver: predicts each accepted transaction, then offers the next one.
    always @(posedge i_clk) begin : driver
        t_cmd_input seen;
        t_cmd_input nxt;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                seen.action = i_action;
                seen.data = i_data_byte;
                seen.last = i_last_byte;
                expected_reports.push_back(apply_event(seen));
            end
            if (!i_in_valid || !o_in_stall) begin
                if (!hold_sender && queued_events.size() != 0 &&
                    $urandom_range(99) >= send_idle_pct) begin
                    nxt = queued_events.pop_front();
                    i_in_valid <= 1'b1;
                    i_action <= nxt.action;
                    i_data_byte <= nxt.data;
                    i_last_byte <= nxt.last;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (expected_reports.size() == 0) begin
                    $error("result arrived with no transaction outstanding");
                    mismatches++;
                end else begin
                    check_report(expected_reports.pop_front());
                end
            end
            i_out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("command_packet_validator_core test failed");
            $finish;
        end
    end

    task automatic push_event(logic [1:0] action, logic [7:0] data, logic last);
        t_cmd_input ev;
        ev.action = action;
        ev.data = data;
        ev.last = last;
        queued_events.push_back(ev);
        queued_items++;
    endtask

    task automatic push_word(logic [15:0] w);
        pkt.push_back(w[7:0]);
        pkt.push_back(w[15:8]);
    endtask

    task automatic build_long(logic [7:0] fl, logic [15:0] fwd, logic [15:0] lat,
                              logic [15:0] ja, logic [15:0] jb, logic [15:0] jc,
                              logic [15:0] seq);
        pkt.delete();
        pkt.push_back(cpv_pkg::LONG_FORMAT);
        pkt.push_back(fl);
        push_word(fwd);
        push_word(lat);
        push_word(ja);
        push_word(jb);
        push_word(jc);
        push_word(seq);
    endtask

    task automatic build_short(logic [7:0] version, logic [7:0] fl, logic [15:0] fwd,
                               logic [15:0] lat, logic [15:0] seq);
        pkt.delete();
        pkt.push_back(version);
        pkt.push_back(fl);
        push_word(fwd);
        push_word(lat);
        push_word(seq);
    endtask

    // Queues the assembled bytes; ticks and unused codes may be mixed in between them.
    task automatic send_pkt(int noise_pct);
        for (int k = 0; k < pkt.size(); k++) begin
            if ($urandom_range(99) < noise_pct)
                push_event(($urandom_range(3) == 0) ? ACT_UNUSED : cpv_pkg::ACT_TICK,
                           8'($urandom), 1'($urandom));
            push_event(cpv_pkg::ACT_BYTE, pkt[k], k == pkt.size() - 1);
        end
    endtask

    function automatic logic [15:0] pick_word(int lim);
        int v;
        case ($urandom_range(19))
            0: v = lim;
            1: v = -lim;
            2: v = lim + 1;
            3: v = -lim - 1;
            4: v = 32'h8000;
            5: v = 32'h7FFF;
            6: v = $urandom_range(65535);
            default: v = $urandom_range(2 * lim) - lim;
        endcase
        return v[15:0];
    endfunction

    function automatic logic [15:0] pick_seq();
        int r;
        r = $urandom_range(19);
        if (r < 2) return gen_seq;
        if (r < 4) return gen_seq - 16'($urandom_range(1, 300));
        if (r == 4) return gen_seq + 16'h8000;
        if (r == 5) gen_seq = gen_seq + 16'h7FFF;
        else gen_seq = gen_seq + 16'($urandom_range(1, 5));
        return gen_seq;
    endfunction

    task automatic add_random_packet();
        int kind;
        logic [7:0] fl;
        logic [15:0] seq;
        kind = $urandom_range(99);
        seq = pick_seq();
        if (kind < 45) begin
            if ($urandom_range(9) < 8) fl = {3'b000, 2'($urandom_range(2)), 3'($urandom)};
            else fl = 8'($urandom);
            build_long(fl, pick_word(SPEED_MAX), pick_word(SPEED_MAX), pick_word(JOINT_MAX),
                       pick_word(JOINT_MAX), pick_word(JOINT_MAX), seq);
        end else if (kind < 88) begin
            if ($urandom_range(9) < 8) fl = {5'b00000, 3'($urandom)};
            else fl = 8'($urandom);
            build_short(($urandom_range(19) == 0) ? 8'($urandom) : cfg_version, fl,
                        pick_word(SPEED_MAX), pick_word(SPEED_MAX), seq);
        end else begin
            pkt.delete();
            repeat ($urandom_range(1, 40)) pkt.push_back(8'($urandom));
            case ($urandom_range(2))
                0: pkt[0] = cpv_pkg::LONG_FORMAT;
                1: pkt[0] = cfg_version;
                default: ;
            endcase
        end
        // Occasionally damage the framing: cut short or run long.
        if ($urandom_range(19) == 0 && pkt.size() > 1)
            repeat ($urandom_range(1, pkt.size() - 1)) void'(pkt.pop_back());
        else if ($urandom_range(19) == 0)
            repeat ($urandom_range(1, 26)) pkt.push_back(8'($urandom));
        send_pkt(8);
    endtask

    task automatic fill_random(int target);
        int start;
        int pick;
        int n;
        start = queued_items;
        while (queued_items - start < target) begin
            pick = $urandom_range(99);
            if (pick < 68) begin
                add_random_packet();
            end else if (pick < 86) begin
                // Some bursts are sized to walk the command age across the timeout.
                if (pick < 72 && cfg_timeout < 16'd300)
                    n = int'(cfg_timeout) + $urandom_range(2);
                else
                    n = $urandom_range(1, 12);
                repeat (n) push_event(cpv_pkg::ACT_TICK, 8'($urandom), 1'($urandom));
            end else if (pick < 90) begin
                push_event(cpv_pkg::ACT_SESSION, 8'($urandom), 1'($urandom));
            end else if (pick < 93) begin
                push_event(ACT_UNUSED, 8'($urandom), 1'($urandom));
            end else begin
                push_event(cpv_pkg::ACT_BYTE, 8'($urandom), $urandom_range(9) == 0);
            end
        end
    endtask

    task automatic set_config(logic [7:0] version, logic [15:0] timeout);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= cpv_pkg::CFG_SHORT_VERSION;
        i_cfg_data <= {8'h00, version};
        @(posedge i_clk);
        i_cfg_index <= cpv_pkg::CFG_TIMEOUT;
        i_cfg_data <= timeout;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        cfg_version = version;
        cfg_timeout = timeout;
    endtask

    // Lets the driver run until the queue is empty and every result is back.
    task automatic run_phase();
        hold_sender <= 1'b0;
        do @(negedge i_clk);
        while (queued_events.size() != 0 || i_in_valid || expected_reports.size() != 0);
        hold_sender <= 1'b1;
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic fill_directed();
        push_event(cpv_pkg::ACT_TICK, 8'hFF, 1'b1);
        push_event(ACT_UNUSED, 8'h00, 1'b0);
        build_short(8'h01, 8'h07, 16'(SPEED_MAX), 16'(-SPEED_MAX), 16'hFFFF);
        send_pkt(0);
        // Sequence zero follows 0xFFFF across the wrap.
        build_long(8'h12, 16'(-SPEED_MAX), 16'(SPEED_MAX), 16'(JOINT_MAX), 16'(-JOINT_MAX),
                   16'h0000, 16'h0000);
        send_pkt(0);
        build_long(8'h08, '0, '0, '0, '0, '0, 16'h0000);
        send_pkt(0);
        build_long(8'h08, '0, '0, '0, '0, '0, 16'h8000);
        send_pkt(0);
        build_long(8'h18, '0, '0, '0, '0, '0, 16'h0001);
        send_pkt(0);
        build_long(8'h20, '0, '0, '0, '0, '0, 16'h0001);
        send_pkt(0);
        build_long(8'h00, 16'(SPEED_MAX + 1), '0, '0, '0, '0, 16'h0001);
        send_pkt(0);
        build_long(8'h00, '0, '0, '0, '0, 16'(-JOINT_MAX - 1), 16'h0001);
        send_pkt(0);
        build_short(8'h01, 8'h08, '0, '0, 16'h0001);
        send_pkt(0);
        build_short(8'h00, 8'h00, '0, '0, 16'h0001);
        send_pkt(0);
        build_short(8'h01, 8'h00, '0, 16'(-SPEED_MAX - 1), 16'h0001);
        send_pkt(0);
        build_long(8'h00, '0, '0, '0, '0, '0, 16'h0001);
        void'(pkt.pop_back());
        send_pkt(0);
        // An overlong packet drives the byte count into saturation.
        build_long(8'h00, '0, '0, '0, '0, '0, 16'h0001);
        repeat (30) pkt.push_back(8'hAA);
        send_pkt(0);
        push_event(cpv_pkg::ACT_BYTE, cpv_pkg::LONG_FORMAT, 1'b1);
        build_long(8'h08, 16'd7, 16'(-7), 16'd1, 16'(-1), 16'd2, 16'h0001);
        send_pkt(50);
        // Age reaches the timeout, then passes it.
        repeat (252) push_event(cpv_pkg::ACT_TICK, 8'h00, 1'b0);
        build_long(8'h00, '0, '0, '0, '0, '0, 16'h0002);
        for (int k = 0; k < 5; k++) push_event(cpv_pkg::ACT_BYTE, pkt[k], 1'b0);
        push_event(cpv_pkg::ACT_SESSION, 8'h5A, 1'b1);
        build_short(8'h01, 8'h02, 16'd100, 16'(-100), 16'h8000);
        send_pkt(0);
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_index = cpv_pkg::CFG_SHORT_VERSION;
        i_cfg_data = '0;
        i_in_valid = 1'b0;
        i_action = cpv_pkg::ACT_BYTE;
        i_data_byte = '0;
        i_last_byte = 1'b0;
        i_out_stall = 1'b0;
        cfg_version = 8'd1;
        cfg_timeout = 16'd250;
        clear_assembly();
        clear_held();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        fill_directed();
        run_phase();

        set_config(8'h00, 16'd0);
        fill_random(80);
        run_phase();

        set_config(8'hFF, 16'd5);
        fill_random(80);
        run_phase();

        send_idle_pct <= 83;
        recv_idle_pct <= 15;
        set_config(cpv_pkg::LONG_FORMAT, 16'hFFFF);
        fill_random(80);
        run_phase();

        set_config(8'($urandom), 16'($urandom_range(1, 40)));
        fill_random(80);
        run_phase();

        // Tick run: the age passes the timeout, then a newer long packet makes the command fresh again.
        send_idle_pct <= 0;
        recv_idle_pct <= 0;
        set_config(8'h01, 16'd50);
        push_event(cpv_pkg::ACT_SESSION, 8'h00, 1'b0);
        build_short(8'h01, 8'h05, 16'(-7), 16'd42, 16'h1234);
        send_pkt(0);
        repeat (AGE_RUN) push_event(cpv_pkg::ACT_TICK, 8'($urandom), 1'($urandom));
        build_long(8'h09, 16'd1, 16'd2, 16'd3, 16'd4, 16'd5, 16'h1235);
        send_pkt(0);
        push_event(cpv_pkg::ACT_TICK, 8'h00, 1'b0);
        run_phase();

        set_config(8'h01, 16'd250);
        fill_random(80);
        run_phase();

        if (mismatches == 0)
            $display("command_packet_validator_core test passed");
        else
            $display("command_packet_validator_core test failed");
        $finish;
    end

endmodule

@@ filelist.f @@
hw/rtl/cpv_pkg.sv
hw/rtl/cpv_decode.sv
hw/rtl/command_packet_validator_core.sv
bench/testbench.sv
